[design/tlspq_pkg.sv]
// Shared types and constants for the three-level stable priority queue.
// Used by tlspq_front, tlspq_back and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlspq_pkg;

  localparam int NumLevels = 3;
  localparam int TagW      = 16;
  localparam int CountW    = 6;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [1:0] LVL_HIGH   = 2'd0;
  localparam logic [1:0] LVL_NORMAL = 2'd1;
  localparam logic [1:0] LVL_LOW    = 2'd2;

  // Decoded command word passed from the front to the back.
  typedef struct packed {
    logic            is_pop;
    logic [1:0]      level;
    logic [TagW-1:0] tag;
  } tlspq_cmd_t;

  typedef struct packed {
    logic              accepted;
    logic              level_full;
    logic              removed_valid;
    logic [1:0]        removed_priority;
    logic [TagW-1:0]   removed_tag;
    logic              queue_empty;
    logic [CountW-1:0] entry_count;
  } tlspq_result_t;

  typedef enum logic {
    BK_RUN,
    BK_POP_DATA
  } tlspq_back_state_e;

endpackage

`default_nettype wire

[design/tlspq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tlspq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/tlspq_front.sv]
// Front end: accepts request words, classifies command and level,
// and buffers them in a two-word queue. Depends on tlspq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlspq_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 cmd_i,
  input  wire logic [1:0]           priority_level_i,
  input  wire logic [15:0]          order_tag_i,
  output logic                      cmd_valid_o,
  input  wire logic                 cmd_ready_i,
  output tlspq_pkg::tlspq_cmd_t     cmd_o
);

  tlspq_pkg::tlspq_cmd_t slot_q [2];
  tlspq_pkg::tlspq_cmd_t word_in;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  // Any code other than high or normal maps to the low level.
  always_comb begin
    word_in.is_pop = (cmd_i == tlspq_pkg::CMD_POP);
    word_in.tag    = order_tag_i;
    if (priority_level_i == tlspq_pkg::LVL_HIGH) begin
      word_in.level = tlspq_pkg::LVL_HIGH;
    end else if (priority_level_i == tlspq_pkg::LVL_NORMAL) begin
      word_in.level = tlspq_pkg::LVL_NORMAL;
    end else begin
      word_in.level = tlspq_pkg::LVL_LOW;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= word_in;
    end
  end

endmodule

`default_nettype wire

[design/tlspq_back.sv]
// Back end: per-level ring pointers and fill counts, the tag store RAM,
// and the result register. Depends on tlspq_pkg and tlspq_ram.
`timescale 1ns / 1ps
`default_nettype none

module tlspq_back #(
  parameter int LEVEL_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_valid_i,
  output logic                       cmd_ready_o,
  input  wire tlspq_pkg::tlspq_cmd_t cmd_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output tlspq_pkg::tlspq_result_t   res_o
);

  localparam int PtrW     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int FillW    = $clog2(LEVEL_DEPTH + 1);
  localparam int CntW     = $clog2(tlspq_pkg::NumLevels * LEVEL_DEPTH + 1);
  localparam int StoreW   = (TAG_BITS < tlspq_pkg::TagW) ? TAG_BITS : tlspq_pkg::TagW;
  localparam int RamDepth = tlspq_pkg::NumLevels * (2 ** PtrW);
  localparam int AddrW    = $clog2(RamDepth);

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrW'(LEVEL_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PtrW'(1);
    end
    return n;
  endfunction

  tlspq_pkg::tlspq_back_state_e state_q, state_d;
  logic [PtrW-1:0]  head_q [tlspq_pkg::NumLevels];
  logic [PtrW-1:0]  head_d [tlspq_pkg::NumLevels];
  logic [PtrW-1:0]  tail_q [tlspq_pkg::NumLevels];
  logic [PtrW-1:0]  tail_d [tlspq_pkg::NumLevels];
  logic [FillW-1:0] fill_q [tlspq_pkg::NumLevels];
  logic [FillW-1:0] fill_d [tlspq_pkg::NumLevels];
  logic [CntW-1:0]  total_q, total_d;
  logic             res_valid_q, res_valid_d;
  tlspq_pkg::tlspq_result_t res_q, res_d;
  tlspq_pkg::tlspq_result_t pend_q, pend_d;

  logic             out_free;
  logic             act;
  logic [1:0]       pop_lv;
  logic             pop_found;
  logic [1:0]       ins_lv;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [StoreW-1:0] ram_wdata, ram_rdata;

  assign out_free = !res_valid_q || res_ready_i;
  assign act      = (state_q == tlspq_pkg::BK_RUN) && cmd_valid_i && out_free;
  assign ins_lv   = cmd_i.level;

  // Oldest entry of the highest non-empty level.
  always_comb begin
    pop_found = 1'b1;
    pop_lv    = tlspq_pkg::LVL_LOW;
    priority if (fill_q[0] != '0) begin
      pop_lv = tlspq_pkg::LVL_HIGH;
    end else if (fill_q[1] != '0) begin
      pop_lv = tlspq_pkg::LVL_NORMAL;
    end else if (fill_q[2] != '0) begin
      pop_lv = tlspq_pkg::LVL_LOW;
    end else begin
      pop_found = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlspq_pkg::BK_RUN: begin
        if (act && cmd_i.is_pop && pop_found) begin
          state_d = tlspq_pkg::BK_POP_DATA;
        end
      end
      tlspq_pkg::BK_POP_DATA: begin
        if (out_free) begin
          state_d = tlspq_pkg::BK_RUN;
        end
      end
      default: state_d = tlspq_pkg::BK_RUN;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    total_d     = total_q;
    pend_d      = pend_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    cmd_ready_o = (state_q == tlspq_pkg::BK_RUN) && out_free;

    unique case (state_q)
      tlspq_pkg::BK_RUN: begin
        if (act && !cmd_i.is_pop) begin
          res_d       = '0;
          res_valid_d = 1'b1;
          if (fill_q[ins_lv] == FillW'(LEVEL_DEPTH)) begin
            res_d.level_full = 1'b1;
          end else begin
            ram_we          = 1'b1;
            ram_waddr       = {ins_lv, tail_q[ins_lv]};
            ram_wdata       = StoreW'(cmd_i.tag);
            tail_d[ins_lv]  = ring_next(tail_q[ins_lv]);
            fill_d[ins_lv]  = fill_q[ins_lv] + FillW'(1);
            total_d         = total_q + CntW'(1);
            res_d.accepted  = 1'b1;
          end
          res_d.queue_empty = (total_d == '0);
          res_d.entry_count = tlspq_pkg::CountW'(total_d);
        end else if (act && cmd_i.is_pop) begin
          if (pop_found) begin
            // Read now, deliver once the tag comes out of the RAM.
            ram_re                  = 1'b1;
            ram_raddr               = {pop_lv, head_q[pop_lv]};
            head_d[pop_lv]          = ring_next(head_q[pop_lv]);
            fill_d[pop_lv]          = fill_q[pop_lv] - FillW'(1);
            total_d                 = total_q - CntW'(1);
            pend_d                  = '0;
            pend_d.accepted         = 1'b1;
            pend_d.removed_valid    = 1'b1;
            pend_d.removed_priority = pop_lv;
            pend_d.queue_empty      = (total_d == '0);
            pend_d.entry_count      = tlspq_pkg::CountW'(total_d);
          end else begin
            res_d             = '0;
            res_d.queue_empty = (total_q == '0);
            res_d.entry_count = tlspq_pkg::CountW'(total_q);
            res_valid_d       = 1'b1;
          end
        end
      end
      tlspq_pkg::BK_POP_DATA: begin
        if (out_free) begin
          res_d             = pend_q;
          res_d.removed_tag = tlspq_pkg::TagW'(ram_rdata);
          res_valid_d       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlspq_pkg::BK_RUN;
      total_q     <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < tlspq_pkg::NumLevels; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    pend_q <= pend_d;
  end

  tlspq_ram #(
    .WIDTH (StoreW),
    .DEPTH (RamDepth)
  ) u_tag_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[0] <= FillW'(LEVEL_DEPTH)) && (fill_q[1] <= FillW'(LEVEL_DEPTH)) &&
    (fill_q[2] <= FillW'(LEVEL_DEPTH)))
    else $error("level fill count above ring depth");

  a_total_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q == CntW'(fill_q[0]) + CntW'(fill_q[1]) + CntW'(fill_q[2]))
    else $error("total count out of step with level fills");

  a_pop_data_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlspq_pkg::BK_POP_DATA) && !$past(state_q == tlspq_pkg::BK_POP_DATA) |->
      $past(cmd_valid_i && cmd_ready_o && cmd_i.is_pop))
    else $error("tag read state entered without an accepted pop");

  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.level_full && res_q.accepted) &&
      !(res_q.removed_valid && !res_q.accepted))
    else $error("inconsistent result flags");

endmodule

`default_nettype wire

[design/three_level_stable_priority_queue.sv]
// Top level of the three-level stable priority queue: front queue plus back end.
// Depends on tlspq_pkg, tlspq_front, tlspq_back (and tlspq_ram through the back).
//
//   Channel  Handshake                  Word
//   in       in_valid_i / in_ready_o    cmd_i, priority_level_i, order_tag_i
//   out      out_valid_o / out_ready_i  accepted_o .. entry_count_o
//
// A pop reads the tag store RAM, which has a registered read port, and delivers
// its result from BK_POP_DATA; an insert needs no read. The front buffers two
// words, so requests are taken while the back end works or a result waits.
// Reset clears pointers, fill counts and control; the tag store is not cleared
// because fill counts guard every read. Either side may stall independently.
`timescale 1ns / 1ps
`default_nettype none

module three_level_stable_priority_queue #(
  parameter int LEVEL_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [1:0]  priority_level_i,
  input  wire logic [15:0] order_tag_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             accepted_o,
  output logic             level_full_o,
  output logic             removed_valid_o,
  output logic [1:0]       removed_priority_o,
  output logic [15:0]      removed_tag_o,
  output logic             queue_empty_o,
  output logic [5:0]       entry_count_o
);

  tlspq_pkg::tlspq_cmd_t    cmd_word;
  tlspq_pkg::tlspq_result_t res;
  logic                     cmd_valid;
  logic                     cmd_ready;

  tlspq_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .priority_level_i (priority_level_i),
    .order_tag_i      (order_tag_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_ready_i      (cmd_ready),
    .cmd_o            (cmd_word)
  );

  tlspq_back #(
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd_word),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign accepted_o         = res.accepted;
  assign level_full_o       = res.level_full;
  assign removed_valid_o    = res.removed_valid;
  assign removed_priority_o = res.removed_priority;
  assign removed_tag_o      = res.removed_tag;
  assign queue_empty_o      = res.queue_empty;
  assign entry_count_o      = res.entry_count;

endmodule

`default_nettype wire

[tb/three_level_stable_priority_queue_test.sv]
// Self-checking testbench for the three-level stable priority queue.
// Depends on tlspq_pkg and the RTL; a behavioral queue predicts every result word.
`timescale 1ns / 1ps

module three_level_stable_priority_queue_test;

  localparam int RingDepth = 16;
  localparam int ShownMismatches = 10;
  localparam int RequestTotal = 1820;
  localparam logic [1:0] LvlOther = 2'd3;

  typedef struct packed {
    logic                       cmd;
    logic [1:0]                 level;
    logic [tlspq_pkg::TagW-1:0] tag;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = tlspq_pkg::CMD_INSERT;
  logic [1:0]  priority_level_i = tlspq_pkg::LVL_HIGH;
  logic [15:0] order_tag_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic        accepted_o;
  logic        level_full_o;
  logic        removed_valid_o;
  logic [1:0]  removed_priority_o;
  logic [15:0] removed_tag_o;
  logic        queue_empty_o;
  logic [5:0]  entry_count_o;

  request_t                 request_list[$];
  tlspq_pkg::tlspq_result_t due_results[$];
  int unsigned              words_taken = 0;
  int unsigned              mismatch_count = 0;
  int unsigned              cycle_no = 0;

  logic [tlspq_pkg::TagW-1:0] ring_tag[tlspq_pkg::NumLevels][RingDepth];
  int unsigned                ring_head[tlspq_pkg::NumLevels];
  int unsigned                ring_tail[tlspq_pkg::NumLevels];
  int unsigned                ring_fill[tlspq_pkg::NumLevels];

  three_level_stable_priority_queue uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .priority_level_i   (priority_level_i),
    .order_tag_i        (order_tag_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .accepted_o         (accepted_o),
    .level_full_o       (level_full_o),
    .removed_valid_o    (removed_valid_o),
    .removed_priority_o (removed_priority_o),
    .removed_tag_o      (removed_tag_o),
    .queue_empty_o      (queue_empty_o),
    .entry_count_o      (entry_count_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_no <= cycle_no + 1;

  // Advance the behavioral queue by one request and return its result word.
  function automatic tlspq_pkg::tlspq_result_t queue_outcome(request_t req);
    tlspq_pkg::tlspq_result_t res;
    int unsigned              lv;
    int unsigned              total;
    res = '0;
    if (req.cmd == tlspq_pkg::CMD_INSERT) begin
      lv = (req.level >= tlspq_pkg::LVL_LOW) ? tlspq_pkg::LVL_LOW : req.level;
      if (ring_fill[lv] == RingDepth) begin
        res.level_full = 1'b1;
      end else begin
        ring_tag[lv][ring_tail[lv]] = req.tag;
        ring_tail[lv] = (ring_tail[lv] + 1) % RingDepth;
        ring_fill[lv]++;
        res.accepted = 1'b1;
      end
    end else begin
      lv = 0;
      while (lv < tlspq_pkg::NumLevels && ring_fill[lv] == 0) lv++;
      if (lv < tlspq_pkg::NumLevels) begin
        res.removed_tag = ring_tag[lv][ring_head[lv]];
        res.removed_priority = lv[1:0];
        res.removed_valid = 1'b1;
        res.accepted = 1'b1;
        ring_head[lv] = (ring_head[lv] + 1) % RingDepth;
        ring_fill[lv]--;
      end
    end
    total = ring_fill[0] + ring_fill[1] + ring_fill[2];
    res.queue_empty = (total == 0);
    res.entry_count = total[tlspq_pkg::CountW-1:0];
    return res;
  endfunction

  function automatic string describe(tlspq_pkg::tlspq_result_t r);
    return $sformatf("acc=%0d full=%0d rvalid=%0d rprio=%0d rtag=%h empty=%0d count=%0d",
                     r.accepted, r.level_full, r.removed_valid, r.removed_priority,
                     r.removed_tag, r.queue_empty, r.entry_count);
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= ShownMismatches) $display("%0t: %s", $realtime, msg);
  endtask

  // Both sides run without gaps inside one window of cycles.
  function automatic logic pause_now();
    return (cycle_no < 700 || cycle_no >= 1300) && ($urandom_range(99) < 16);
  endfunction

  task automatic add_request(logic cmd, logic [1:0] level, logic [tlspq_pkg::TagW-1:0] tag);
    request_t req;
    req.cmd = cmd;
    req.level = level;
    req.tag = tag;
    request_list.push_back(req);
  endtask

  // Driver: predict on acceptance, then present the next word or idle.
  always @(posedge clk_i) begin
    request_t nxt;
    logic     hold;
    if (rst_ni) begin
      hold = in_valid_i && !in_ready_o;
      if (in_valid_i && in_ready_o) begin
        due_results.push_back(queue_outcome({cmd_i, priority_level_i, order_tag_i}));
        words_taken++;
      end
      if (!hold) begin
        if (request_list.size() != 0 && !pause_now()) begin
          nxt = request_list.pop_front();
          cmd_i <= nxt.cmd;
          priority_level_i <= nxt.level;
          order_tag_i <= nxt.tag;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest prediction.
  always @(posedge clk_i) begin
    tlspq_pkg::tlspq_result_t seen;
    tlspq_pkg::tlspq_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen = {accepted_o, level_full_o, removed_valid_o, removed_priority_o,
                removed_tag_o, queue_empty_o, entry_count_o};
        if (due_results.size() == 0) begin
          note_mismatch({"unexpected result word: ", describe(seen)});
        end else begin
          want = due_results.pop_front();
          if (seen !== want)
            note_mismatch({"result mismatch: expected ", describe(want),
                           " / actual ", describe(seen)});
        end
      end
      out_ready_i <= !pause_now();
    end
  end

  initial begin
    int unsigned                insert_pct;
    int unsigned                burst_len;
    int unsigned                pin;
    logic [1:0]                 lvl;
    logic [tlspq_pkg::TagW-1:0] tag;

    // Pop on empty, every level incl. the code-three alias, FIFO order within a level.
    add_request(tlspq_pkg::CMD_POP, tlspq_pkg::LVL_HIGH, 16'h0000);
    add_request(tlspq_pkg::CMD_INSERT, LvlOther, 16'hFFFF);
    add_request(tlspq_pkg::CMD_INSERT, tlspq_pkg::LVL_NORMAL, 16'h8001);
    add_request(tlspq_pkg::CMD_INSERT, tlspq_pkg::LVL_HIGH, 16'h0000);
    add_request(tlspq_pkg::CMD_INSERT, tlspq_pkg::LVL_LOW, 16'h5AA5);
    add_request(tlspq_pkg::CMD_INSERT, tlspq_pkg::LVL_HIGH, 16'hA55A);
    repeat (5) add_request(tlspq_pkg::CMD_POP, LvlOther, 16'hFFFF);
    // Fill the low ring, then overflow it.
    for (int i = 0; i < RingDepth; i++)
      add_request(tlspq_pkg::CMD_INSERT, (i % 2) ? LvlOther : tlspq_pkg::LVL_LOW,
                  (i % 2) ? tlspq_pkg::TagW'(16'hFFFF - i) : tlspq_pkg::TagW'(i));
    add_request(tlspq_pkg::CMD_INSERT, LvlOther, 16'h7FFE);

    // Random bursts: insert-heavy to fill rings, pop-heavy to drain them.
    while (request_list.size() < RequestTotal) begin
      case ($urandom_range(2))
        0: insert_pct = 90;
        1: insert_pct = 55;
        default: insert_pct = 15;
      endcase
      burst_len = $urandom_range(20, 70);
      pin = $urandom_range(4);
      repeat (burst_len) begin
        lvl = 2'($urandom_range(3));
        if (pin < 4 && $urandom_range(3) != 0) lvl = pin[1:0];
        tag = tlspq_pkg::TagW'($urandom_range(16'hFFFF));
        if ($urandom_range(99) < insert_pct) add_request(tlspq_pkg::CMD_INSERT, lvl, tag);
        else add_request(tlspq_pkg::CMD_POP, lvl, tag);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_list.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[three_level_stable_priority_queue.f]
design/tlspq_pkg.sv
design/tlspq_ram.sv
design/tlspq_front.sv
design/tlspq_back.sv
design/three_level_stable_priority_queue.sv
tb/three_level_stable_priority_queue_test.sv
